// ===== rtl/core/swlp_pkg.sv =====
package swlp_pkg;

  // Window geometry and field widths.
  localparam int WINDOW  = 100;
  localparam int DATA_W  = 16;
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int TOTAL_W = 32;
  localparam int MIN_W   = 7;
  localparam int CMP_W   = (FILL_W > MIN_W) ? FILL_W : MIN_W;

  // Register reset value.
  localparam logic [MIN_W-1:0] MIN_SAMPLES_RESET = MIN_W'(5);

  // Percentile ranks: floor(n * pct / 100) is taken as (n * pct * recip) >> RECIP_SH,
  // where recip = ceil(2^RECIP_SH / 100). This is exact for n * pct below 2^17.
  localparam int PCT_BASE = 100;
  localparam int PCT_HIGH = 95;
  localparam int PCT_TOP  = 99;
  localparam int RECIP_SH = 24;
  localparam longint RECIP = ((64'd1 << RECIP_SH) + PCT_BASE - 1) / PCT_BASE;
  localparam int MUL_W = RECIP_SH + 8;
  localparam logic [MUL_W-1:0] MUL_HIGH = MUL_W'(PCT_HIGH * RECIP);
  localparam logic [MUL_W-1:0] MUL_TOP  = MUL_W'(PCT_TOP * RECIP);
  localparam int PROD_W = FILL_W + MUL_W;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DEL  = 4'b0010,
    ST_INS  = 4'b0100,
    ST_SEL  = 4'b1000
  } state_t;

  // Command broadcast to every cell of the sorted chain.
  typedef struct packed {
    logic              del;
    logic              ins;
    logic [DATA_W-1:0] dv;
    logic [DATA_W-1:0] x;
  } cell_ctl_t;

endpackage

// ===== rtl/core/sliding_window_latency_percentiles.sv =====
// An accepted transaction passes through eviction, insertion into the sorted cell
// row and rank selection before its result is registered; a stalled output holds it in selection.
// A new transaction is taken only in idle, after the last one has left, as the single cell row is shared.
// Reset (synchronous, rst_n low): window empty, write slot, fill and total at zero,
// min_samples at 5, output empty. The sample ring itself is not cleared.
module sliding_window_latency_percentiles (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] query latency
  input  logic [0:0]  in_tuser,   // [0] success
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [15:0] p50, [31:16] p95, [47:32] p99,
                                  // [54:48] window_fill, [86:55] total_successes, [87] zero
  output logic [0:0]  out_tuser,  // [0] stats_ready
  // Configuration.
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata   // min_samples
);

  swlp_pkg::state_t state_r, state_nxt;

  logic [swlp_pkg::DATA_W-1:0]  x_r, dv_r;
  logic                         ok_r;
  logic [swlp_pkg::SLOT_W-1:0]  slot_r;
  logic [swlp_pkg::FILL_W-1:0]  fill_r;
  logic [swlp_pkg::TOTAL_W-1:0] total_r;
  logic [swlp_pkg::MIN_W-1:0]   min_r;
  logic [swlp_pkg::SLOT_W-1:0]  rank50_r, rank95_r, rank99_r;
  logic [swlp_pkg::DATA_W-1:0]  ring [swlp_pkg::WINDOW];

  logic                         out_vld_r;
  logic [87:0]                  out_data_r;
  logic                         out_rdy_r;

  logic                         in_acc, out_load;
  logic [swlp_pkg::PROD_W-1:0]  prod95, prod99;
  logic [swlp_pkg::DATA_W-1:0]  p50, p95, p99;
  swlp_pkg::cell_ctl_t          ctl;

  assign in_tready = (state_r == swlp_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == swlp_pkg::ST_SEL) && (!out_vld_r || out_tready);

  // Sequencer: evict, insert, select, one step per cycle; selection waits while the output is stalled.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swlp_pkg::ST_IDLE: if (in_acc) state_nxt = swlp_pkg::ST_DEL;
      swlp_pkg::ST_DEL:  state_nxt = swlp_pkg::ST_INS;
      swlp_pkg::ST_INS:  state_nxt = swlp_pkg::ST_SEL;
      swlp_pkg::ST_SEL:  if (out_load) state_nxt = swlp_pkg::ST_IDLE;
      default:           state_nxt = swlp_pkg::ST_IDLE;
    endcase
  end

  // Commands for the cell row.
  always_comb begin
    ctl.del = (state_r == swlp_pkg::ST_DEL) && ok_r &&
              (fill_r == swlp_pkg::FILL_W'(swlp_pkg::WINDOW));
    ctl.ins = (state_r == swlp_pkg::ST_INS) && ok_r;
    ctl.dv  = dv_r;
    ctl.x   = x_r;
  end

  // Percentile ranks from the fill count.
  assign prod95 = swlp_pkg::PROD_W'(fill_r) * swlp_pkg::PROD_W'(swlp_pkg::MUL_HIGH);
  assign prod99 = swlp_pkg::PROD_W'(fill_r) * swlp_pkg::PROD_W'(swlp_pkg::MUL_TOP);

  swlp_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .rank50 (rank50_r),
    .rank95 (rank95_r),
    .rank99 (rank99_r),
    .p50    (p50),
    .p95    (p95),
    .p99    (p99)
  );

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= swlp_pkg::ST_IDLE;
      slot_r    <= '0;
      fill_r    <= '0;
      total_r   <= '0;
      min_r     <= swlp_pkg::MIN_SAMPLES_RESET;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        min_r <= cfg_wdata;
      end
      if ((state_r == swlp_pkg::ST_DEL) && ok_r) begin
        if (slot_r == swlp_pkg::SLOT_W'(swlp_pkg::WINDOW - 1)) begin
          slot_r <= '0;
        end else begin
          slot_r <= slot_r + 1'b1;
        end
        if (fill_r != swlp_pkg::FILL_W'(swlp_pkg::WINDOW)) begin
          fill_r <= fill_r + 1'b1;
        end
        if (total_r != '1) begin
          total_r <= total_r + 1'b1;
        end
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Sample ring: evicted value read on acceptance, a successful new sample written the cycle after.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dv_r <= ring[slot_r];
    end
    if ((state_r == swlp_pkg::ST_DEL) && ok_r) begin
      ring[slot_r] <= x_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r  <= in_tdata;
      ok_r <= in_tuser[0];
    end
    if (state_r == swlp_pkg::ST_INS) begin
      rank50_r <= swlp_pkg::SLOT_W'(fill_r >> 1);
      rank95_r <= prod95[swlp_pkg::RECIP_SH +: swlp_pkg::SLOT_W];
      rank99_r <= prod99[swlp_pkg::RECIP_SH +: swlp_pkg::SLOT_W];
    end
    if (out_load) begin
      out_data_r <= {1'b0, total_r, 7'(fill_r), p99, p95, p50};
      out_rdy_r  <= (swlp_pkg::CMP_W'(fill_r) >= swlp_pkg::CMP_W'(min_r));
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_rdy_r;

endmodule

// ===== rtl/core/swlp_cell.sv =====
module swlp_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swlp_pkg::cell_ctl_t            ctl,
  input  logic [swlp_pkg::DATA_W-1:0]    up_val,
  input  logic                           up_vld,
  input  logic [swlp_pkg::DATA_W-1:0]    dn_val,
  input  logic                           dn_vld,
  input  logic                           dn_le,
  output logic [swlp_pkg::DATA_W-1:0]    val,
  output logic                           vld,
  output logic                           le
);

  logic [swlp_pkg::DATA_W-1:0] val_r, val_nxt;
  logic                        vld_r, vld_nxt;

  // A valid cell at or below the new sample keeps its place on insertion.
  assign le  = vld_r && (val_r <= ctl.x);
  assign val = val_r;
  assign vld = vld_r;

  // Deletion pulls the upper neighbor down from the evicted value upward.
  // Insertion pushes cells above the new sample up by one place.
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.del) begin
      if (vld_r && (val_r >= ctl.dv)) begin
        val_nxt = up_val;
        vld_nxt = up_vld;
      end
    end else if (ctl.ins) begin
      if (!le) begin
        if (dn_le) begin
          val_nxt = ctl.x;
          vld_nxt = 1'b1;
        end else begin
          val_nxt = dn_val;
          vld_nxt = dn_vld;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/core/swlp_chain.sv =====
module swlp_chain (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swlp_pkg::cell_ctl_t            ctl,
  input  logic [swlp_pkg::SLOT_W-1:0]    rank50,
  input  logic [swlp_pkg::SLOT_W-1:0]    rank95,
  input  logic [swlp_pkg::SLOT_W-1:0]    rank99,
  output logic [swlp_pkg::DATA_W-1:0]    p50,
  output logic [swlp_pkg::DATA_W-1:0]    p95,
  output logic [swlp_pkg::DATA_W-1:0]    p99
);

  logic [swlp_pkg::DATA_W-1:0] val [swlp_pkg::WINDOW];
  logic                        vld [swlp_pkg::WINDOW];
  logic                        le  [swlp_pkg::WINDOW];

  // Sorted row of cells, smallest value in cell zero.
  for (genvar i = 0; i < swlp_pkg::WINDOW; i++) begin : g_cell
    logic [swlp_pkg::DATA_W-1:0] up_val, dn_val;
    logic                        up_vld, dn_vld, dn_le;

    if (i == swlp_pkg::WINDOW - 1) begin : g_top
      assign up_val = '0;
      assign up_vld = 1'b0;
    end else begin : g_mid
      assign up_val = val[i+1];
      assign up_vld = vld[i+1];
    end

    if (i == 0) begin : g_bot
      assign dn_val = '0;
      assign dn_vld = 1'b0;
      assign dn_le  = 1'b1;
    end else begin : g_low
      assign dn_val = val[i-1];
      assign dn_vld = vld[i-1];
      assign dn_le  = le[i-1];
    end

    swlp_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .up_val (up_val),
      .up_vld (up_vld),
      .dn_val (dn_val),
      .dn_vld (dn_vld),
      .dn_le  (dn_le),
      .val    (val[i]),
      .vld    (vld[i]),
      .le     (le[i])
    );
  end

  // Each cell matches its own position against the ranks; an empty cell reads as zero.
  always_comb begin
    p50 = '0;
    p95 = '0;
    p99 = '0;
    for (int i = 0; i < swlp_pkg::WINDOW; i++) begin
      if (vld[i] && (rank50 == swlp_pkg::SLOT_W'(i))) p50 = p50 | val[i];
      if (vld[i] && (rank95 == swlp_pkg::SLOT_W'(i))) p95 = p95 | val[i];
      if (vld[i] && (rank99 == swlp_pkg::SLOT_W'(i))) p99 = p99 | val[i];
    end
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  import swlp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 400;

  // One expected result transaction, one member per output field but the pad bit.
  typedef struct packed {
    logic [DATA_W-1:0]  p50;
    logic [DATA_W-1:0]  p95;
    logic [DATA_W-1:0]  p99;
    logic [FILL_W-1:0]  fill;
    logic [TOTAL_W-1:0] total;
    logic               ready;
  } window_stats_t;

  // Window tracker: keeps its own copy of the sample ring and counters and
  // queues the statistics each accepted query should produce.
  class pctl_scoreboard;
    bit [DATA_W-1:0]  ring [WINDOW];
    int unsigned      slot;
    int unsigned      fill;
    bit [TOTAL_W-1:0] total;
    bit [MIN_W-1:0]   min_fill;
    window_stats_t    stats_due [$];
    int unsigned      errors;
    int unsigned      checked;

    function new();
      slot = 0;
      fill = 0;
      total = '0;
      min_fill = MIN_SAMPLES_RESET;
      errors = 0;
      checked = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
    endtask

    // Record an accepted query and work out the window statistics it yields.
    function void note_query(bit [DATA_W-1:0] lat, bit ok);
      bit [DATA_W-1:0] win [WINDOW];
      bit [DATA_W-1:0] key;
      int              i;
      int              j;
      window_stats_t   s;
      if (ok) begin
        ring[slot] = lat;
        slot = (slot + 1) % WINDOW;
        if (fill < WINDOW) fill++;
        if (total != '1) total++;
      end
      // Sort the occupied part of the ring ascending.
      for (i = 0; i < fill; i++) begin
        win[i] = ring[i];
      end
      for (i = 1; i < fill; i++) begin
        key = win[i];
        j = i;
        while (j > 0 && win[j-1] > key) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = key;
      end
      s = '0;
      if (fill > 0) begin
        s.p50 = win[fill / 2];
        s.p95 = win[(fill * PCT_HIGH) / PCT_BASE];
        s.p99 = win[(fill * PCT_TOP) / PCT_BASE];
      end
      s.fill = FILL_W'(fill);
      s.total = total;
      s.ready = (fill >= min_fill);
      stats_due.push_back(s);
    endfunction

    // Compare one accepted result transaction against the oldest expectation.
    task check_stats(logic [87:0] d, logic [0:0] u);
      window_stats_t e;
      checked++;
      if (stats_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending", checked));
        return;
      end
      e = stats_due.pop_front();
      if (d[15:0] !== e.p50)
        report($sformatf("result %0d p50 %0d, expected %0d", checked, d[15:0], e.p50));
      if (d[31:16] !== e.p95)
        report($sformatf("result %0d p95 %0d, expected %0d", checked, d[31:16], e.p95));
      if (d[47:32] !== e.p99)
        report($sformatf("result %0d p99 %0d, expected %0d", checked, d[47:32], e.p99));
      if (d[54:48] !== e.fill)
        report($sformatf("result %0d fill %0d, expected %0d", checked, d[54:48], e.fill));
      if (d[86:55] !== e.total)
        report($sformatf("result %0d total %0d, expected %0d", checked, d[86:55], e.total));
      if (d[87] !== 1'b0)
        report($sformatf("result %0d pad bit is %b", checked, d[87]));
      if (u[0] !== e.ready)
        report($sformatf("result %0d ready %b, expected %b", checked, u[0], e.ready));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  pctl_scoreboard sb;
  int unsigned    quiet_cycles = 0;
  int unsigned    queries_sent = 0;
  int unsigned    cfg_writes = 0;
  bit             long_hold_done = 1'b0;

  sliding_window_latency_percentiles dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: every transaction is observed at the rising edge. A result is
  // checked before the same edge's query is noted; it cannot belong to it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_stats(out_tdata, out_tuser);
      if (in_tvalid && in_tready) sb.note_query(in_tdata, in_tuser[0]);
      if (cfg_we) sb.min_fill = cfg_wdata;
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("sliding_window_latency_percentiles verification failed");
        $finish;
      end
    end
  end

  // Receiver: switches at random between stall patterns, and holds off
  // once for a long stretch so the block backs up into its input.
  initial begin
    int          mode;
    int unsigned left;
    int unsigned period;
    int unsigned tick;
    mode = 0;
    left = 0;
    period = 2;
    tick = 0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && sb != null && sb.checked >= HOLD_AFTER) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(32, 200);
          period = $urandom_range(2, 7);
        end
        left--;
        tick++;
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = $urandom_range(0, 1);
          2: out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = (tick % period == 0);
        endcase
      end
    end
  end

  // Offer one query and hold it until the block takes it.
  task automatic send_query(logic [15:0] lat, logic ok);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = lat;
    in_tuser = ok;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    queries_sent++;
  endtask

  task automatic idle_gap(int unsigned n);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has been checked.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.stats_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // The threshold is changed only with the block idle.
  task automatic write_min_samples(logic [6:0] v);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_writes++;
  endtask

  // Random bursts of queries; latencies lean towards clusters and the
  // extremes so duplicates and ties are common.
  task automatic run_random(int unsigned count);
    int unsigned burst;
    int unsigned sel;
    logic [15:0] lat;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
      end
      burst--;
      sel = $urandom_range(0, 19);
      if (sel < 8) begin
        lat = 16'($urandom_range(0, 200));
      end else if (sel < 14) begin
        lat = 16'($urandom);
      end else if (sel < 17) begin
        lat = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      end else begin
        lat = 16'($urandom_range(950, 1050));
      end
      send_query(lat, $urandom_range(0, 6) != 0);
    end
  endtask

  initial begin
    logic [6:0] thresholds [6];
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A zero threshold marks even the empty window ready.
    write_min_samples(7'd0);
    send_query(16'hFFFF, 1'b0);
    send_query(16'h1234, 1'b0);
    send_query(16'h00FF, 1'b1);

    // Back to the reset threshold: extremes, failures in between, and the
    // ready flag rising as the fill reaches five.
    write_min_samples(7'd5);
    send_query(16'h0000, 1'b1);
    send_query(16'hFFFF, 1'b1);
    send_query(16'hABCD, 1'b0);
    send_query(16'h8000, 1'b1);
    send_query(16'h7FFF, 1'b1);
    send_query(16'h0001, 1'b1);
    send_query(16'hAAAA, 1'b1);
    send_query(16'h5555, 1'b1);
    send_query(16'h0007, 1'b1);
    send_query(16'h0007, 1'b1);
    send_query(16'h0007, 1'b1);
    send_query(16'hFFFF, 1'b0);
    send_query(16'hFFFE, 1'b1);

    // Random phases, each under its own threshold, including two above the
    // window size so the ready flag never rises.
    thresholds[0] = 7'd127;
    thresholds[1] = 7'd100;
    thresholds[2] = 7'd1;
    thresholds[3] = 7'd101;
    thresholds[4] = 7'($urandom_range(1, 100));
    thresholds[5] = 7'($urandom_range(1, 100));
    foreach (thresholds[p]) begin
      write_min_samples(thresholds[p]);
      run_random(190);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d queries and %0d results over %0d threshold settings.",
             queries_sent, sb.checked, cfg_writes);
    $display("Window wrapped repeatedly; output back-pressure hold applied: %0d.",
             long_hold_done);
    if (sb.errors == 0) begin
      $display("sliding_window_latency_percentiles verification clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("sliding_window_latency_percentiles verification failed");
    end
    $finish;
  end

endmodule
